// File: hw/rtl/sst_pkg.sv
// Shared constants, codes and control/status types for the software timer table.
`timescale 1ns / 1ps

package sst_pkg;

    localparam int NUM_TIMERS = 16;
    localparam int CNT_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    // input item modes
    localparam logic [1:0] MODE_CHARGE = 2'd0;
    localparam logic [1:0] MODE_ADD    = 2'd1;
    localparam logic [1:0] MODE_REMOVE = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ONESHOT  = 2'd0;
    localparam logic [1:0] KIND_PERIODIC = 2'd1;
    localparam logic [1:0] KIND_SUMMARY  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;   // latch the accepted beat, apply add/remove to the slot
        logic chk;    // one step of the earliest-timer check (add only)
        logic scn;    // one step of the charge/min scan
        logic sum;    // emit the summary beat
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic cnt_last;  // slot counter at the last slot
        logic out_free;  // output register can take a beat this cycle
        logic in_add;    // incoming beat is a valid add
    } t_sts;

endpackage

// File: hw/rtl/sst_ctrl.sv
// Sequencer for the software timer table: accept, check pass, scan pass, summary.
`timescale 1ns / 1ps

module sst_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  sst_pkg::t_sts i_sts,
    output sst_pkg::t_cmd o_cmd
);
    import sst_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_SUMM  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.in_add ? ST_CHECK : ST_SCAN;
                end
            end
            ST_CHECK: begin
                o_cmd.chk = 1'b1;
                if (i_sts.cnt_last) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (i_sts.out_free) begin
                    o_cmd.scn = 1'b1;
                    if (i_sts.cnt_last) begin
                        n_state = ST_SUMM;
                    end
                end
            end
            ST_SUMM: begin
                if (i_sts.out_free) begin
                    o_cmd.sum = 1'b1;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// File: hw/rtl/sst_dp.sv
// Timer table storage, slot counter, charge/min datapath and output register.
`timescale 1ns / 1ps

module sst_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  sst_pkg::t_cmd i_cmd,
    output sst_pkg::t_sts o_sts,
    input  logic [1:0]    i_mode,
    input  logic [3:0]    i_timer_index,
    input  logic [31:0]   i_start_time,
    input  logic [31:0]   i_reload_period,
    input  logic [31:0]   i_elapsed,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [1:0]    o_kind,
    output logic [3:0]    o_which_timer,
    output logic [31:0]   o_next_wait,
    output logic          o_charged,
    output logic [63:0]   o_tick_total,
    output logic          o_last
);
    import sst_pkg::*;

    // table
    logic [31:0]           r_rem [NUM_TIMERS];
    logic [31:0]           r_rld [NUM_TIMERS];
    logic [NUM_TIMERS-1:0] r_act;
    logic [63:0]           r_total;

    // latched beat and pass state
    logic [31:0]      r_el;
    logic [31:0]      r_start;
    logic [CNT_W-1:0] r_idx;
    logic [CNT_W-1:0] r_cnt;
    logic             r_charge;
    logic             r_any;
    logic [31:0]      r_best;

    // decode of incoming beat
    logic [32:0]      in_sum;
    logic [31:0]      in_sat;
    logic [CNT_W-1:0] in_idx;
    logic             in_ok;

    // scan step
    logic [31:0] cur_rem;
    logic [31:0] cur_rld;
    logic        cur_act;
    logic [31:0] n_rem;
    logic        n_act;
    logic        emit;
    logic [1:0]  emit_kind;
    logic        beats_new;
    logic        n_any;
    logic [31:0] n_best;
    logic [63:0] n_total;
    logic        cnt_last;
    logic        out_free;

    assign in_sum = {1'b0, i_start_time} + {1'b0, i_elapsed};
    assign in_sat = in_sum[32] ? 32'hFFFF_FFFF : in_sum[31:0];
    assign in_idx = CNT_W'(i_timer_index);
    assign in_ok  = (int'(i_timer_index) < NUM_TIMERS);

    assign cur_rem  = r_rem[r_cnt];
    assign cur_rld  = r_rld[r_cnt];
    assign cur_act  = r_act[r_cnt];
    assign cnt_last = (r_cnt == CNT_W'(NUM_TIMERS - 1));
    assign out_free = !o_out_valid || !i_out_stall;

    // another active slot that already comes first beats the new timer
    assign beats_new = cur_act && (r_cnt != r_idx) &&
                       ((cur_rem < r_start) || ((cur_rem == r_start) && (r_cnt < r_idx)));

    always_comb begin
        n_rem     = cur_rem;
        n_act     = cur_act;
        emit      = 1'b0;
        emit_kind = KIND_ONESHOT;
        if (r_charge && cur_act) begin
            if (cur_rem <= r_el) begin
                emit = 1'b1;
                if (cur_rld != 32'd0) begin
                    n_rem     = cur_rld;
                    emit_kind = KIND_PERIODIC;
                end else begin
                    n_rem = 32'd0;
                    n_act = 1'b0;
                end
            end else begin
                n_rem = cur_rem - r_el;
            end
        end
        n_any  = r_any;
        n_best = r_best;
        if (n_act && (!r_any || (n_rem < r_best))) begin
            n_any  = 1'b1;
            n_best = n_rem;
        end
    end

    assign n_total = r_total + (r_charge ? {32'd0, r_el} : 64'd0);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act       <= '0;
            r_total     <= '0;
            r_cnt       <= '0;
            r_charge    <= 1'b0;
            r_any       <= 1'b0;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cnt <= '0;
                r_any <= 1'b0;
                priority if (i_mode == MODE_CHARGE) begin
                    r_charge <= 1'b1;
                end else if ((i_mode == MODE_ADD) && in_ok) begin
                    r_act[in_idx] <= 1'b1;
                    r_charge      <= 1'b1;
                end else if ((i_mode == MODE_REMOVE) && in_ok && r_act[in_idx]) begin
                    r_act[in_idx] <= 1'b0;
                    r_charge      <= 1'b1;
                end else begin
                    r_charge <= 1'b0;
                end
            end
            if (i_cmd.chk) begin
                if (beats_new) begin
                    r_charge <= 1'b0;
                end
                r_cnt <= cnt_last ? '0 : r_cnt + CNT_W'(1);
            end
            if (i_cmd.scn) begin
                r_act[r_cnt] <= n_act;
                r_any        <= n_any;
                r_cnt        <= cnt_last ? '0 : r_cnt + CNT_W'(1);
            end
            if (i_cmd.sum) begin
                r_total <= n_total;
            end
            if ((i_cmd.scn && emit) || i_cmd.sum) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_el    <= i_elapsed;
            r_start <= in_sat;
            r_idx   <= in_idx;
            r_best  <= 32'd0;
            if ((i_mode == MODE_ADD) && in_ok) begin
                r_rem[in_idx] <= in_sat;
                r_rld[in_idx] <= i_reload_period;
            end
        end
        if (i_cmd.scn) begin
            r_rem[r_cnt] <= n_rem;
            r_best       <= n_best;
        end
        if (i_cmd.scn && emit) begin
            o_kind        <= emit_kind;
            o_which_timer <= 4'(r_cnt);
            o_next_wait   <= 32'd0;
            o_charged     <= 1'b1;
            o_tick_total  <= 64'd0;
            o_last        <= 1'b0;
        end else if (i_cmd.sum) begin
            o_kind        <= KIND_SUMMARY;
            o_which_timer <= 4'd0;
            o_next_wait   <= r_any ? r_best : 32'd0;
            o_charged     <= r_charge;
            o_tick_total  <= n_total;
            o_last        <= 1'b1;
        end
    end

    assign o_sts.cnt_last = cnt_last;
    assign o_sts.out_free = out_free;
    assign o_sts.in_add   = (i_mode == MODE_ADD) && in_ok;

endmodule

// File: hw/rtl/software_timer_table.sv
// Software timer table top level: one-shot and periodic timers with charge and summary.
// Order: an item's beat is latched, an add then runs its check pass over all slots, and
//   every item scans all slots, emitting expiry beats, and ends with the summary beat.
//   The passes go one slot a cycle, the scan held while a result waits in a stalled
//   output; a new item is taken only once the summary beat has been issued.
// Reset: synchronous, active low; clears active flags and tick total, no clearing pass.
`timescale 1ns / 1ps

module software_timer_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [3:0]  i_timer_index,
    input  logic [31:0] i_start_time,
    input  logic [31:0] i_reload_period,
    input  logic [31:0] i_elapsed,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [3:0]  o_which_timer,
    output logic [31:0] o_next_wait,
    output logic        o_charged,
    output logic [63:0] o_tick_total,
    output logic        o_last
);
    import sst_pkg::*;

    t_cmd cmd;
    t_sts sts;

    // Sequencer: IDLE takes one beat, an add runs the earliest check, every item
    // then scans all slots (charging when needed, emitting expiries in slot
    // order, folding the minimum) and finishes with the summary beat.
    sst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Table, counter and output register. The output register decouples the
    // scan from the consumer; the scan advances only when it can take a beat.
    sst_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_mode          (i_mode),
        .i_timer_index   (i_timer_index),
        .i_start_time    (i_start_time),
        .i_reload_period (i_reload_period),
        .i_elapsed       (i_elapsed),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_kind          (o_kind),
        .o_which_timer   (o_which_timer),
        .o_next_wait     (o_next_wait),
        .o_charged       (o_charged),
        .o_tick_total    (o_tick_total),
        .o_last          (o_last)
    );

endmodule
